// ----- design/cpcf_pkg.sv -----
`default_nettype none

package cpcf_pkg;

  // Widths of the channel fields.
  localparam int PORT_CELL_BITS = 16;
  localparam int FACE_BITS      = 10;

  // Defaults for the top level parameters.
  localparam int MAX_COARSE_FACES = 1024;
  localparam int TABLE_SLOTS      = 2048;
  localparam int CELL_BITS        = 16;

  localparam logic OWNER_SIDE_RESET = 1'b1;

  // Control flags that travel with a word from one cell to the next.
  typedef struct packed {
    logic valid;    // a word sits in this stage
    logic restart;  // the word clears every cell it passes
    logic done;     // the word has been matched or has claimed a cell
    logic is_new;   // the word claimed a cell
  } ctl_t;

endpackage

`default_nettype wire

// ----- design/cpcf_in_if.sv -----
`default_nettype none

interface cpcf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                restart;
  logic [cpcf_pkg::PORT_CELL_BITS-1:0] local_cell;
  logic [cpcf_pkg::PORT_CELL_BITS-1:0] neighbour_cell;

  modport source (output valid, output restart, output local_cell, output neighbour_cell,
                  input ready);
  modport sink   (input valid, input restart, input local_cell, input neighbour_cell,
                  output ready);
endinterface

`default_nettype wire

// ----- design/cpcf_out_if.sv -----
`default_nettype none

interface cpcf_out_if;
  logic                                valid;
  logic                                ready;
  logic [cpcf_pkg::FACE_BITS-1:0]      coarse_face;
  logic                                is_new;
  logic [cpcf_pkg::PORT_CELL_BITS-1:0] face_cell;
  logic                                overflow;

  modport source (output valid, output coarse_face, output is_new, output face_cell,
                  output overflow, input ready);
  modport sink   (input valid, input coarse_face, input is_new, input face_cell,
                  input overflow, output ready);
endinterface

`default_nettype wire

// ----- design/cpcf_cfg_if.sv -----
`default_nettype none

interface cpcf_cfg_if;
  logic valid;
  logic ready;
  logic owner_side;

  modport source (output valid, output owner_side, input ready);
  modport sink   (input valid, input owner_side, output ready);
endinterface

`default_nettype wire

// ----- design/cpcf_cell.sv -----
`default_nettype none

// One table entry of the chain. Its face number is its own position, since
// entries are claimed strictly from the front of the chain.
module cpcf_cell #(
  parameter int CELL_BITS = cpcf_pkg::CELL_BITS,
  parameter int FACE_W    = 10,
  parameter int IDX       = 0
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      adv_i,
  input  wire  cpcf_pkg::ctl_t     ctl_i,
  input  wire  [2*CELL_BITS-1:0]   key_i,
  input  wire  [CELL_BITS-1:0]     loc_i,
  input  wire  [FACE_W-1:0]        face_i,
  output cpcf_pkg::ctl_t           ctl_o,
  output logic [2*CELL_BITS-1:0]   key_o,
  output logic [CELL_BITS-1:0]     loc_o,
  output logic [FACE_W-1:0]        face_o
);

  localparam logic [FACE_W-1:0] MY_FACE = FACE_W'(IDX);

  logic                   vld_q, vld_d;
  logic [2*CELL_BITS-1:0] ent_key_q;
  cpcf_pkg::ctl_t         ctl_q, ctl_d;
  logic [2*CELL_BITS-1:0] key_q;
  logic [CELL_BITS-1:0]   loc_q;
  logic [FACE_W-1:0]      face_q, face_d;
  logic                   vld_eff;
  logic                   claim;

  always_comb begin
    // A restarting word empties this entry before it is looked at.
    vld_eff = vld_q & ~(ctl_i.valid & ctl_i.restart);
    ctl_d   = ctl_i;
    face_d  = face_i;
    claim   = 1'b0;
    if (ctl_i.valid && !ctl_i.done) begin
      if (!vld_eff) begin
        claim        = 1'b1;
        ctl_d.done   = 1'b1;
        ctl_d.is_new = 1'b1;
        face_d       = MY_FACE;
      end else if (ent_key_q == key_i) begin
        ctl_d.done   = 1'b1;
        ctl_d.is_new = 1'b0;
        face_d       = MY_FACE;
      end
    end
    vld_d = vld_eff | claim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      ctl_q <= '0;
    end else if (adv_i) begin
      vld_q <= vld_d;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (claim) begin
        ent_key_q <= key_i;
      end
      key_q  <= key_i;
      loc_q  <= loc_i;
      face_q <= face_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign key_o  = key_q;
  assign loc_o  = loc_q;
  assign face_o = face_q;

endmodule

`default_nettype wire

// ----- design/cell_pair_coarse_face_numbering_unit.sv -----
`default_nettype none

// Channel  Dir  Handshake     Word
// cfg_i    in   valid/ready   owner_side
// in_i     in   valid/ready   restart, local_cell, neighbour_cell
// out_o    out  valid/ready   coarse_face, is_new, face_cell, overflow
//
// Every word walks a chain of DEPTH cells, DEPTH = min(MAX_COARSE_FACES, TABLE_SLOTS),
// one cell per cycle unless the chain holds, and then enters the output register.
// A new word is taken every cycle unless the chain holds: one word per cycle.
// Reset empties every cell at once and sets owner_side to 1.
// While a finished word waits at the output and is not taken, the whole chain holds.
module cell_pair_coarse_face_numbering_unit #(
  parameter int MAX_COARSE_FACES = cpcf_pkg::MAX_COARSE_FACES,
  parameter int TABLE_SLOTS      = cpcf_pkg::TABLE_SLOTS,
  parameter int CELL_BITS        = cpcf_pkg::CELL_BITS
) (
  input wire         clk_i,
  input wire         rst_ni,
  cpcf_cfg_if.sink   cfg_i,
  cpcf_in_if.sink    in_i,
  cpcf_out_if.source out_o
);

  localparam int PB     = cpcf_pkg::PORT_CELL_BITS;
  localparam int FB     = cpcf_pkg::FACE_BITS;
  localparam int DEPTH  = (MAX_COARSE_FACES < TABLE_SLOTS) ? MAX_COARSE_FACES : TABLE_SLOTS;
  localparam int FACE_W = $clog2(DEPTH);

  logic                 owner_q;
  logic                 adv;
  logic [CELL_BITS+PB-1:0] loc_ext, nbr_ext;
  logic [CELL_BITS-1:0] loc_c, nbr_c;

  cpcf_pkg::ctl_t         ctl_w  [DEPTH+1];
  logic [2*CELL_BITS-1:0] key_w  [DEPTH+1];
  logic [CELL_BITS-1:0]   loc_w  [DEPTH+1];
  logic [FACE_W-1:0]      face_w [DEPTH+1];

  logic                  out_vld_q;
  logic [FB-1:0]         out_face_q, out_face_d;
  logic                  out_new_q, out_new_d;
  logic [PB-1:0]         out_cell_q, out_cell_d;
  logic                  out_ovf_q, out_ovf_d;
  logic [FACE_W+FB-1:0]  face_ext;
  logic [CELL_BITS+PB-1:0] cell_ext;

  // Configuration.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= cpcf_pkg::OWNER_SIDE_RESET;
    end else if (cfg_i.valid) begin
      owner_q <= cfg_i.owner_side;
    end
  end

  // Keying of the incoming word.
  assign adv        = ~out_vld_q | out_o.ready;
  assign in_i.ready = adv;

  assign loc_ext = {{CELL_BITS{1'b0}}, in_i.local_cell};
  assign nbr_ext = {{CELL_BITS{1'b0}}, in_i.neighbour_cell};
  assign loc_c   = loc_ext[CELL_BITS-1:0];
  assign nbr_c   = nbr_ext[CELL_BITS-1:0];

  always_comb begin
    ctl_w[0]         = '0;
    ctl_w[0].valid   = in_i.valid;
    ctl_w[0].restart = in_i.restart;
    key_w[0]         = owner_q ? {loc_c, nbr_c} : {nbr_c, loc_c};
    loc_w[0]         = loc_c;
    face_w[0]        = '0;
  end

  // The chain.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cpcf_cell #(
      .CELL_BITS (CELL_BITS),
      .FACE_W    (FACE_W),
      .IDX       (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (ctl_w[g]),
      .key_i  (key_w[g]),
      .loc_i  (loc_w[g]),
      .face_i (face_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .key_o  (key_w[g+1]),
      .loc_o  (loc_w[g+1]),
      .face_o (face_w[g+1])
    );
  end

  // A word that leaves the chain unresolved found neither its pair nor a free entry.
  assign face_ext = {{FB{1'b0}}, face_w[DEPTH]};
  assign cell_ext = {{PB{1'b0}}, loc_w[DEPTH]};

  always_comb begin
    out_face_d = ctl_w[DEPTH].done ? face_ext[FB-1:0] : '0;
    out_new_d  = ctl_w[DEPTH].done & ctl_w[DEPTH].is_new;
    out_cell_d = out_new_d ? cell_ext[PB-1:0] : '0;
    out_ovf_d  = ~ctl_w[DEPTH].done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= ctl_w[DEPTH].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_face_q <= out_face_d;
      out_new_q  <= out_new_d;
      out_cell_q <= out_cell_d;
      out_ovf_q  <= out_ovf_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.coarse_face = out_face_q;
  assign out_o.is_new      = out_new_q;
  assign out_o.face_cell   = out_cell_q;
  assign out_o.overflow    = out_ovf_q;

endmodule

`default_nettype wire
